### hdl/lzwc_pkg.sv
// Package: shared constants, types and command/status structs for the LZ window compressor.
package lzwc_pkg;

    localparam int MaxWindowBits = 14;
    localparam int MaxLookahead  = 16;
    localparam int MaxRun        = 31;

    localparam logic [3:0] ResetWindowBits = 4'd11;
    localparam logic [2:0] ResetLengthBits = 3'd4;
    localparam logic [2:0] ResetRunBits    = 3'd3;

    localparam logic [1:0] RegWindowBits = 2'd0;
    localparam logic [1:0] RegLengthBits = 2'd1;
    localparam logic [1:0] RegRunBits    = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic take_byte;     // write accepted byte into lookahead
        logic scan_start;    // clear best, set distance 1
        logic scan_step;     // compare one candidate distance
        logic commit;        // apply the token decision
        logic put_bits;      // push a field into the bit packer
        logic [1:0] field;   // which field
        logic pad;           // pad packer to a byte
        logic emit_run;      // emit run byte at index
        logic clear;         // end of stream clear
    } lzwc_cmd_t;

    localparam logic [1:0] FieldZeroL  = 2'd0;
    localparam logic [1:0] FieldCount  = 2'd1;
    localparam logic [1:0] FieldMatch  = 2'd2;
    localparam logic [1:0] FieldEnd    = 2'd3;

    // datapath -> controller
    typedef struct packed {
        logic la_full;       // lookahead holds F bytes
        logic la_empty;
        logic scan_done;     // all distances compared
        logic is_literal;    // best length is one
        logic run_full;      // run at maximum
        logic run_nonempty;
        logic run_emit_done; // run bytes all emitted
        logic out_busy;      // packer holds >= 8 bits, hold register cannot load, or a commit is moving bytes
        logic bits_pending;  // packer holds a partial byte
    } lzwc_sts_t;

endpackage

### hdl/lzwc_stream_if.sv
// Interface: valid/ready word channel with a generic payload.
interface lzwc_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/lzwc_ctrl.sv
// Controller: sequences byte intake, window scan, token coding and drain.
module lzwc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_ready,
    output lzwc_pkg::lzwc_cmd_t cmd,
    input  lzwc_pkg::lzwc_sts_t sts,
    output logic                mark_end,   // word done: newest held byte is its last
    output logic                mark_stream
);
    import lzwc_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_CHECK  = 12'b000000000010,
        S_SCAN   = 12'b000000000100,
        S_DECIDE = 12'b000000001000,
        S_FLUSHL = 12'b000000010000,
        S_FLUSHC = 12'b000000100000,
        S_FLUSHP = 12'b000001000000,
        S_FLUSHB = 12'b000010000000,
        S_MATCH  = 12'b000100000000,
        S_ENDB   = 12'b001000000000,
        S_ENDP   = 12'b010000000000,
        S_ENDM   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic   last_reg, last_next;
    logic   after_reg, after_next;   // flush is followed by a match token
    logic   mfld_reg, mfld_next;     // match: 0 length field, 1 distance field
    logic   endf_reg, endf_next;     // flush is part of the drain

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
            after_reg <= 1'b0;
            mfld_reg  <= 1'b0;
            endf_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            after_reg <= after_next;
            mfld_reg  <= mfld_next;
            endf_reg  <= endf_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        after_next = after_reg;
        mfld_next  = mfld_reg;
        endf_next  = endf_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        mark_end   = 1'b0;
        mark_stream = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = !sts.out_busy;
                if (in_valid && !sts.out_busy)
                begin
                    cmd.take_byte = 1'b1;
                    last_next = in_last;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.out_busy)
                    state_next = S_CHECK;
                else if (sts.la_full || (last_reg && !sts.la_empty))
                begin
                    cmd.scan_start = 1'b1;
                    state_next = S_SCAN;
                end
                else if (last_reg)
                begin
                    if (sts.run_nonempty)
                    begin
                        endf_next = 1'b1;
                        after_next = 1'b0;
                        state_next = S_FLUSHL;
                    end
                    else
                        state_next = S_ENDB;
                end
                else
                begin
                    mark_end = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                    state_next = S_DECIDE;
                else
                    cmd.scan_step = 1'b1;
            end
            S_DECIDE:
            begin
                if (sts.is_literal)
                begin
                    if (sts.run_full)
                    begin
                        after_next = 1'b0;
                        endf_next = 1'b0;
                        state_next = S_FLUSHL;
                    end
                    else
                    begin
                        cmd.commit = 1'b1;
                        state_next = S_CHECK;
                    end
                end
                else if (sts.run_nonempty)
                begin
                    after_next = 1'b1;
                    endf_next = 1'b0;
                    state_next = S_FLUSHL;
                end
                else
                begin
                    mfld_next = 1'b0;
                    state_next = S_MATCH;
                end
            end
            S_FLUSHL:
            begin
                if (!sts.out_busy)
                begin
                    cmd.put_bits = 1'b1;
                    cmd.field = FieldZeroL;
                    state_next = S_FLUSHC;
                end
            end
            S_FLUSHC:
            begin
                if (!sts.out_busy)
                begin
                    cmd.put_bits = 1'b1;
                    cmd.field = FieldCount;
                    state_next = S_FLUSHP;
                end
            end
            S_FLUSHP:
            begin
                if (!sts.out_busy)
                begin
                    cmd.pad = 1'b1;
                    state_next = S_FLUSHB;
                end
            end
            S_FLUSHB:
            begin
                if (!sts.out_busy)
                begin
                    if (sts.run_emit_done)
                    begin
                        if (endf_reg)
                            state_next = S_ENDB;
                        else if (after_reg)
                        begin
                            mfld_next = 1'b0;
                            state_next = S_MATCH;
                        end
                        else
                            state_next = S_DECIDE; // run now empty, literal joins
                    end
                    else
                        cmd.emit_run = 1'b1;
                end
            end
            S_MATCH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.put_bits = 1'b1;
                    cmd.field = FieldMatch;
                    if (mfld_reg)
                    begin
                        cmd.commit = 1'b1;
                        state_next = S_CHECK;
                    end
                    mfld_next = 1'b1;
                end
            end
            S_ENDB:
            begin
                if (!sts.out_busy)
                begin
                    cmd.put_bits = 1'b1;
                    cmd.field = FieldEnd;
                    state_next = S_ENDP;
                end
            end
            S_ENDP:
            begin
                if (!sts.out_busy)
                begin
                    cmd.pad = 1'b1;
                    state_next = S_ENDM;
                end
            end
            S_ENDM:
            begin
                if (!sts.out_busy)
                begin
                    cmd.clear = 1'b1;
                    mark_end = 1'b1;
                    mark_stream = 1'b1;
                    last_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/lzwc_datapath.sv
// Datapath: window memory, lookahead, match scan, literal run and bit packer.
module lzwc_datapath #(
    parameter int MAX_WINDOW_BITS = lzwc_pkg::MaxWindowBits,
    parameter int MAX_LOOKAHEAD   = lzwc_pkg::MaxLookahead,
    parameter int MAX_RUN         = lzwc_pkg::MaxRun
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [3:0]          window_bits,
    input  logic [2:0]          length_bits,
    input  logic [2:0]          run_bits,
    input  logic [7:0]          in_byte,
    input  lzwc_pkg::lzwc_cmd_t cmd,
    output lzwc_pkg::lzwc_sts_t sts,
    input  logic                mark_end,
    input  logic                mark_stream,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                run_end,
    output logic                stream_end
);
    import lzwc_pkg::*;

    localparam int WinDepth = 1 << MAX_WINDOW_BITS;
    localparam int AW  = MAX_WINDOW_BITS;
    localparam int LAW = $clog2(MAX_LOOKAHEAD + 1);
    localparam int LIW = $clog2(MAX_LOOKAHEAD);
    localparam int RW  = $clog2(MAX_RUN + 1);
    localparam int RIW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int DW  = MAX_WINDOW_BITS + 1;

    // effective settings
    logic [4:0] eff_n;
    logic [2:0] eff_l, eff_s;
    logic [LAW-1:0] f_len;
    logic [RW-1:0] run_max;
    logic [DW-1:0] wf;
    always_comb
    begin
        eff_n = (window_bits < 4'd9) ? 5'd9 : {1'b0, window_bits};
        if (eff_n > 5'(MAX_WINDOW_BITS))
            eff_n = 5'(MAX_WINDOW_BITS);
        eff_l = (length_bits < 3'd3) ? 3'd3 : ((length_bits > 3'd4) ? 3'd4 : length_bits);
        if ((6'd1 << eff_l) > 6'(MAX_LOOKAHEAD))
            eff_l = 3'd3;
        eff_s = (run_bits < 3'd1) ? 3'd1 : ((run_bits > 3'd5) ? 3'd5 : run_bits);
        f_len = LAW'(6'd1 << eff_l);
        if ((6'd1 << eff_s) - 6'd1 > 6'(MAX_RUN))
            run_max = RW'(MAX_RUN);
        else
            run_max = RW'((6'd1 << eff_s) - 6'd1);
        wf = DW'((17'd1 << eff_n) - 17'(f_len));
    end

    // state
    logic [7:0] win_mem [WinDepth];
    logic [7:0] la_reg [MAX_LOOKAHEAD];
    logic [7:0] run_mem [MAX_RUN];
    logic [LAW-1:0] la_fill_reg;
    logic [DW-1:0]  fill_reg;
    logic [AW-1:0]  head_reg;
    logic [RW-1:0]  run_cnt_reg, run_idx_reg;
    logic [31:0]    acc_reg;
    logic [5:0]     bits_reg;

    // scan: distance d, len counter (offset into candidate)
    logic [DW-1:0]  d_reg, lim_reg;
    logic [LAW-1:0] len_reg, best_reg;
    logic [DW-1:0]  bestd_reg;
    logic           rd_pend_reg;  // window read data valid next cycle
    logic [7:0]     win_q_reg;
    logic           run_rd_reg;
    logic [7:0]     run_q_reg;

    // output register, fed from a hidden hold register: a word is shown only once
    // its run_end flag is known
    logic       ov_reg;
    logic [7:0] ob_reg;
    logic       oe_reg, os_reg;
    logic       hv_reg;
    logic [7:0] hb_reg;

    logic [LAW-1:0] cap;
    logic [LAW-1:0] fm1;
    always_comb
    begin
        fm1 = f_len - LAW'(1);
        cap = (la_fill_reg < fm1) ? la_fill_reg : fm1;
    end

    // candidate byte for current (d, len)
    logic [7:0] cand;
    logic       from_win;
    logic [AW-1:0] win_addr;
    always_comb
    begin
        from_win = DW'(len_reg) < d_reg;
        win_addr = head_reg - AW'(d_reg) + AW'(len_reg);
        cand = from_win ? win_q_reg : la_reg[LIW'(DW'(len_reg) - d_reg)];
    end

    logic scanning_reg;
    logic cmp_ok, cand_end;
    always_comb
    begin
        cmp_ok = (len_reg < cap) && (cand == la_reg[LIW'(len_reg)]);
        cand_end = !cmp_ok;
    end

    // window read: registered data; a candidate byte from the window waits for the registered read
    always_ff @(posedge clk)
    begin
        win_q_reg <= win_mem[win_addr];
        run_q_reg <= run_mem[RIW'(run_idx_reg)];
    end

    logic [LAW-1:0] best_lit;
    assign best_lit = (best_reg > la_fill_reg) ? la_fill_reg : best_reg;

    // commit: move best_lit bytes window-ward one a cycle
    logic [LAW-1:0] mv_reg;
    logic           moving_reg;

    always_ff @(posedge clk)
    begin
        if (moving_reg)
            win_mem[head_reg] <= la_reg[0];
    end

    logic bits_first_reg;

    // packer field
    logic [15:0] fv;
    logic [4:0]  fn;
    always_comb
    begin
        fv = '0;
        fn = '0;
        case (cmd.field)
            FieldZeroL:
            begin
                fv = '0;
                fn = {2'b0, eff_l};
            end
            FieldCount:
            begin
                fv = 16'(run_cnt_reg);
                fn = {2'b0, eff_s};
            end
            FieldMatch:
            begin
                if (bits_first_reg)
                begin
                    fv = 16'(best_lit - LAW'(1));
                    fn = {2'b0, eff_l};
                end
                else
                begin
                    fv = 16'(bestd_reg);
                    fn = eff_n;
                end
            end
            FieldEnd:
            begin
                fv = '0;
                fn = 5'(eff_l) + 5'(eff_s);
            end
            default:
            begin
                fv = '0;
                fn = '0;
            end
        endcase
    end

    logic out_take;
    assign out_take = ov_reg && out_ready;
    logic can_load;
    assign can_load = !hv_reg || !ov_reg || out_take;

    // new packed word into the hold register
    logic       ld;
    logic [7:0] ld_byte;
    always_comb
    begin
        ld = 1'b0;
        ld_byte = '0;
        if (cmd.put_bits)
            ld = 1'b0;
        else if (bits_reg >= 6'd8)
        begin
            ld = can_load;
            ld_byte = 8'(acc_reg >> (bits_reg - 6'd8));
        end
        else if (cmd.pad)
        begin
            ld = (bits_reg != '0);
            ld_byte = 8'(acc_reg << (6'd8 - bits_reg));
        end
        else if (cmd.emit_run)
        begin
            ld = run_rd_reg;
            ld_byte = run_q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            la_fill_reg <= '0;
            fill_reg <= '0;
            head_reg <= '0;
            run_cnt_reg <= '0;
            run_idx_reg <= '0;
            acc_reg <= '0;
            bits_reg <= '0;
            d_reg <= '0;
            lim_reg <= '0;
            len_reg <= '0;
            best_reg <= '0;
            bestd_reg <= '0;
            rd_pend_reg <= 1'b0;
            scanning_reg <= 1'b0;
            mv_reg <= '0;
            moving_reg <= 1'b0;
            ov_reg <= 1'b0;
            ob_reg <= '0;
            oe_reg <= 1'b0;
            os_reg <= 1'b0;
            hv_reg <= 1'b0;
            hb_reg <= '0;
            bits_first_reg <= 1'b1;
            run_rd_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take_byte && la_fill_reg < LAW'(MAX_LOOKAHEAD))
            begin
                la_reg[LIW'(la_fill_reg)] <= in_byte;
                la_fill_reg <= la_fill_reg + LAW'(1);
            end
            if (cmd.scan_start)
            begin
                d_reg <= DW'(1);
                lim_reg <= (fill_reg < wf) ? fill_reg : wf;
                len_reg <= '0;
                best_reg <= LAW'(1);
                bestd_reg <= '0;
                rd_pend_reg <= 1'b1;
                scanning_reg <= 1'b1;
            end
            else if (cmd.scan_step)
            begin
                if (d_reg > lim_reg)
                    scanning_reg <= 1'b0;
                else if (rd_pend_reg)
                    rd_pend_reg <= 1'b0;
                else if (cand_end)
                begin
                    if (len_reg > best_reg)
                    begin
                        best_reg <= len_reg;
                        bestd_reg <= d_reg;
                    end
                    d_reg <= d_reg + DW'(1);
                    len_reg <= '0;
                    rd_pend_reg <= 1'b1;
                end
                else
                begin
                    len_reg <= len_reg + LAW'(1);
                    rd_pend_reg <= (DW'(len_reg) + DW'(1)) < d_reg;
                end
            end
            if (cmd.commit)
            begin
                if (best_lit == LAW'(1) && run_cnt_reg < RW'(MAX_RUN))
                begin
                    run_mem[RIW'(run_cnt_reg)] <= la_reg[0];
                    run_cnt_reg <= run_cnt_reg + RW'(1);
                end
                mv_reg <= best_lit;
                moving_reg <= 1'b1;
            end
            if (moving_reg)
            begin
                head_reg <= head_reg + AW'(1);
                for (int i = 0; i < MAX_LOOKAHEAD - 1; i++)
                    la_reg[i] <= la_reg[i+1];
                la_fill_reg <= la_fill_reg - LAW'(1);
                fill_reg <= ((fill_reg + DW'(1)) > wf) ? wf : fill_reg + DW'(1);
                mv_reg <= mv_reg - LAW'(1);
                if (mv_reg == LAW'(1))
                    moving_reg <= 1'b0;
            end
            if (cmd.put_bits)
            begin
                acc_reg <= (acc_reg << fn) | 32'(fv & ((16'd1 << fn) - 16'd1));
                bits_reg <= bits_reg + 6'(fn);
                if (cmd.field == FieldMatch)
                    bits_first_reg <= !bits_first_reg;
            end
            else if (bits_reg >= 6'd8)
            begin
                if (can_load)
                begin
                    bits_reg <= bits_reg - 6'd8;
                    acc_reg <= acc_reg & ((32'd1 << (bits_reg - 6'd8)) - 32'd1);
                end
            end
            else if (cmd.pad)
            begin
                acc_reg <= '0;
                bits_reg <= '0;
                run_idx_reg <= '0;
                run_rd_reg <= 1'b0;
            end
            else if (cmd.emit_run)
            begin
                if (!run_rd_reg)
                    run_rd_reg <= 1'b1;
                else
                begin
                    run_idx_reg <= run_idx_reg + RW'(1);
                    run_rd_reg <= 1'b0;
                    if (run_idx_reg + RW'(1) == run_cnt_reg)
                        run_cnt_reg <= '0;
                end
            end
            // a held word moves out when a newer one arrives (not last) or at word end
            if (ld || (mark_end && hv_reg))
            begin
                if (ld)
                    hb_reg <= ld_byte;
                hv_reg <= ld;
                if (hv_reg)
                begin
                    ov_reg <= 1'b1;
                    ob_reg <= hb_reg;
                    oe_reg <= !ld;
                    os_reg <= !ld && mark_stream;
                end
                else if (out_take)
                    ov_reg <= 1'b0;
            end
            else if (out_take)
                ov_reg <= 1'b0;
            if (cmd.clear)
            begin
                la_fill_reg <= '0;
                fill_reg <= '0;
                head_reg <= '0;
                run_cnt_reg <= '0;
                bits_first_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        sts.la_full       = (la_fill_reg >= f_len) && !moving_reg;
        sts.la_empty      = (la_fill_reg == '0);
        sts.scan_done     = !scanning_reg;
        sts.is_literal    = (best_lit == LAW'(1));
        sts.run_full      = (run_cnt_reg >= run_max);
        sts.run_nonempty  = (run_cnt_reg != '0);
        sts.run_emit_done = (run_cnt_reg == '0);
        sts.out_busy      = (bits_reg >= 6'd8) || moving_reg || !can_load;
        sts.bits_pending  = (bits_reg != '0);
    end

    assign out_valid  = ov_reg;
    assign out_byte   = ob_reg;
    assign run_end    = oe_reg;
    assign stream_end = os_reg;

endmodule

### hdl/lz_window_compressor_core.sv
// Top level: LZ77 sliding-window compressor, configuration registers and channel wiring.
//  channel  dir  payload                        handshake
//  in       in   in_byte[7:0], is_last          valid/ready
//  out      out  out_byte[7:0], run_end, stream_end  valid/ready
//  cfg      in   cfg_index[1:0], cfg_data[3:0]  cfg_we, no wait
// A token scans every window distance: each distance starts with a window read, then compares
// byte by byte, with another read before each further window byte; committing then moves the
// token's bytes into the window one by one.
// Reset clears control state; window bytes are never read before written.
// Packed words pass a hold register (shown once run_end is known) and the output register;
// a full output stalls the packer, and the input is held off while a token runs.
module lz_window_compressor_core #(
    parameter int MAX_WINDOW_BITS = lzwc_pkg::MaxWindowBits,
    parameter int MAX_LOOKAHEAD   = lzwc_pkg::MaxLookahead,
    parameter int MAX_RUN         = lzwc_pkg::MaxRun
)
(
    input  logic        clk,
    input  logic        rst_n,
    lzwc_stream_if.sink   in_ch,
    lzwc_stream_if.source out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);
    import lzwc_pkg::*;

    logic [3:0] window_bits_reg;
    logic [2:0] length_bits_reg, run_bits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_bits_reg <= ResetWindowBits;
            length_bits_reg <= ResetLengthBits;
            run_bits_reg    <= ResetRunBits;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegWindowBits: window_bits_reg <= cfg_data;
                RegLengthBits: length_bits_reg <= cfg_data[2:0];
                RegRunBits:    run_bits_reg    <= cfg_data[2:0];
                default:       ;
            endcase
        end
    end

    lzwc_cmd_t cmd;
    lzwc_sts_t sts;
    logic mark_end, mark_stream;
    logic [7:0] ob;
    logic oe, os;

    lzwc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_last(in_ch.data[0]), .in_ready(in_ch.ready),
        .cmd(cmd), .sts(sts), .mark_end(mark_end), .mark_stream(mark_stream)
    );

    lzwc_datapath #(
        .MAX_WINDOW_BITS(MAX_WINDOW_BITS),
        .MAX_LOOKAHEAD(MAX_LOOKAHEAD),
        .MAX_RUN(MAX_RUN)
    ) u_dp (
        .clk(clk), .rst_n(rst_n),
        .window_bits(window_bits_reg), .length_bits(length_bits_reg),
        .run_bits(run_bits_reg), .in_byte(in_ch.data[8:1]),
        .cmd(cmd), .sts(sts), .mark_end(mark_end), .mark_stream(mark_stream),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_byte(ob), .run_end(oe), .stream_end(os)
    );

    assign out_ch.data = {ob, oe, os};

endmodule

### bench/tb_lz_window_compressor_core.sv
// Testbench: directed and random byte streams checked against a behavioral LZ window predictor.
`timescale 1ns / 1ps

module tb_lz_window_compressor_core;
    import lzwc_pkg::*;

    localparam int WinDepth = 1 << MaxWindowBits;
    localparam int WinMask  = WinDepth - 1;
    localparam int SettleIdle = 200;
    localparam int SettleBusy = 2 * WinDepth + 200;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       stream_end;
    } packed_word_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [3:0] cfg_data;

    lzwc_stream_if #(9)  in_if ();
    lzwc_stream_if #(10) out_if ();

    lz_window_compressor_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_if),
        .out_ch    (out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [3:0] win_bits_reg;
    logic [2:0] len_bits_reg;
    logic [2:0] run_bits_reg;
    logic [7:0] window_mem [WinDepth];
    int unsigned win_fill, win_head;
    logic [7:0] look_mem [MaxLookahead];
    int unsigned look_fill;
    logic [7:0] lit_mem [MaxRun];
    int unsigned lit_count;
    int unsigned acc, acc_bits;
    int unsigned eff_n, eff_l, eff_s, lit_max;

    packed_word_t step_words [$];
    packed_word_t expected_words [$];
    int errors;
    bit quiet_sender;
    bit quiet_sink;
    int stall_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic void pack_word(int unsigned b);
        packed_word_t w;
        w.out_byte = b[7:0];
        w.run_end = 1'b0;
        w.stream_end = 1'b0;
        if (step_words.size() < 64)
            step_words.push_back(w);
    endfunction

    function automatic void put_field(int unsigned v, int unsigned n);
        acc = (acc << n) | (v & ((1 << n) - 1));
        acc_bits += n;
        while (acc_bits >= 8)
        begin
            pack_word(acc >> (acc_bits - 8));
            acc_bits -= 8;
            acc &= (1 << acc_bits) - 1;
        end
    endfunction

    function automatic void pad_byte();
        if (acc_bits > 0)
            pack_word(acc << (8 - acc_bits));
        acc = 0;
        acc_bits = 0;
    endfunction

    function automatic void flush_literals();
        put_field(0, eff_l);
        put_field(lit_count, eff_s);
        pad_byte();
        for (int i = 0; i < lit_count; i++)
            pack_word(lit_mem[i]);
        lit_count = 0;
    endfunction

    function automatic void encode_one();
        int unsigned f, wf, fill, best, best_d, len;
        logic [7:0] b;
        f = 1 << eff_l;
        wf = (1 << eff_n) - f;
        fill = (win_fill < wf) ? win_fill : wf;
        best = 1;
        best_d = 0;
        for (int unsigned d = 1; d <= fill; d++)
        begin
            len = 0;
            while (len < look_fill && len < f - 1)
            begin
                // match may run on into the lookahead
                b = (len < d) ? window_mem[(win_head - d + len) & WinMask] : look_mem[len - d];
                if (b != look_mem[len])
                    break;
                len++;
            end
            if (len > best)
            begin
                best = len;
                best_d = d;
            end
        end
        if (best > look_fill)
            best = look_fill;
        if (best == 1)
        begin
            if (lit_count >= lit_max)
                flush_literals();
            lit_mem[lit_count] = look_mem[0];
            lit_count++;
        end
        else
        begin
            if (lit_count > 0)
                flush_literals();
            put_field(best - 1, eff_l);
            put_field(best_d, eff_n);
        end
        for (int k = 0; k < best; k++)
        begin
            window_mem[win_head & WinMask] = look_mem[k];
            win_head = (win_head + 1) & WinMask;
        end
        win_fill += best;
        if (win_fill > wf)
            win_fill = wf;
        for (int k = 0; k + best < look_fill; k++)
            look_mem[k] = look_mem[k + best];
        look_fill -= best;
    endfunction

    function automatic void clear_stream_state();
        win_fill = 0;
        win_head = 0;
        look_fill = 0;
        lit_count = 0;
        acc = 0;
        acc_bits = 0;
    endfunction

    function automatic void predict_word(logic [7:0] data_byte, logic last);
        step_words.delete();
        eff_n = (win_bits_reg < 9) ? 9 : win_bits_reg;
        if (eff_n > MaxWindowBits)
            eff_n = MaxWindowBits;
        eff_l = (len_bits_reg < 3) ? 3 : ((len_bits_reg > 4) ? 4 : len_bits_reg);
        if ((1 << eff_l) > MaxLookahead)
            eff_l = 3;
        eff_s = (run_bits_reg < 1) ? 1 : ((run_bits_reg > 5) ? 5 : run_bits_reg);
        lit_max = (1 << eff_s) - 1;
        if (lit_max > MaxRun)
            lit_max = MaxRun;
        if (look_fill < MaxLookahead)
        begin
            look_mem[look_fill] = data_byte;
            look_fill++;
        end
        while (look_fill >= (1 << eff_l))
            encode_one();
        if (last)
        begin
            while (look_fill > 0)
                encode_one();
            if (lit_count > 0)
                flush_literals();
            put_field(0, eff_l + eff_s);
            pad_byte();
            if (step_words.size() > 0)
                step_words[step_words.size() - 1].stream_end = 1'b1;
            clear_stream_state();
        end
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].run_end = 1'b1;
        foreach (step_words[i])
            expected_words.push_back(step_words[i]);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_sender || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // valid is left high after a word; only lowered when a gap follows
    // ready is looked at mid-cycle, where it already holds its value for the next edge
    task automatic send_byte(logic [7:0] data_byte, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data <= {data_byte, last};
        do
            @(negedge clk);
        while (!in_if.ready);
        @(posedge clk);
        predict_word(data_byte, last);
    endtask

    task automatic wait_drained(int settle);
        @(posedge clk);
        in_if.valid <= 1'b0;
        while (expected_words.size() > 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            RegWindowBits: win_bits_reg = value;
            RegLengthBits: len_bits_reg = value[2:0];
            RegRunBits:    run_bits_reg = value[2:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [3:0] n, logic [3:0] l, logic [3:0] s);
        write_reg(RegWindowBits, n);
        write_reg(RegLengthBits, l);
        write_reg(RegRunBits, s);
    endtask

    task automatic test_basic_streams();
        send_byte(8'h00, 1'b1);
        wait_drained(SettleIdle);
        send_byte(8'hFF, 1'b0);
        for (int i = 0; i < 12; i++)
            send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        wait_drained(SettleIdle);
    endtask

    task automatic test_clamped_extremes();
        // all fields below range: smallest window, L=3, run max of one
        set_config(4'd0, 4'd0, 4'd0);
        for (int i = 0; i < 6; i++)
            send_byte(8'(i * 37 + 1), 1'b0);
        send_byte(8'h80, 1'b1);
        wait_drained(SettleIdle);
        // all fields above range: largest window, L=4, run of 31
        set_config(4'd15, 4'd7, 4'd7);
        quiet_sender = 1'b1;
        for (int i = 0; i < 40; i++)
            send_byte(8'(i * 13 + 7), i == 39);
        quiet_sender = 1'b0;
        wait_drained(SettleIdle);
    endtask

    task automatic test_config_mid_stream();
        set_config(4'd9, 4'd4, 4'd2);
        for (int i = 0; i < 10; i++)
            send_byte(8'(i % 3), 1'b0);
        // hold off until every pending word is out and the scan has finished
        wait_drained(SettleBusy);
        write_reg(RegLengthBits, 4'd3);
        write_reg(RegRunBits, 4'd5);
        for (int i = 0; i < 6; i++)
            send_byte(8'(i % 2 + 3), i == 5);
        wait_drained(SettleIdle);
    endtask

    task automatic test_random_streams();
        int sent;
        int len;
        logic [7:0] alphabet [3];
        sent = 0;
        while (sent < 30)
        begin
            if ($urandom_range(0, 3) == 0)
                set_config(4'($urandom_range(9, 14)), 4'($urandom_range(0, 7)),
                           4'($urandom_range(0, 7)));
            else
                set_config(4'($urandom_range(0, 15)), 4'($urandom_range(3, 4)),
                           4'($urandom_range(1, 5)));
            quiet_sender = ($urandom_range(0, 3) == 0);
            quiet_sink = ($urandom_range(0, 3) == 0);
            foreach (alphabet[i])
                alphabet[i] = 8'($urandom);
            len = $urandom_range(1, 24);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 9) < 7)
                    send_byte(alphabet[$urandom_range(0, 2)], i == len - 1);
                else
                    send_byte(8'($urandom), i == len - 1);
            end
            sent += len;
            wait_drained(SettleIdle);
        end
        quiet_sender = 1'b0;
        quiet_sink = 1'b0;
    endtask

    // sink side: check mid-cycle the word that the next edge accepts
    always @(negedge clk)
    begin
        packed_word_t got;
        packed_word_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            got = out_if.data;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (got.out_byte !== want.out_byte)
                begin
                    $display("%0t: out_byte expected %h actual %h",
                             $time, want.out_byte, got.out_byte);
                    errors++;
                end
                if (got.run_end !== want.run_end)
                begin
                    $display("%0t: run_end expected %b actual %b",
                             $time, want.run_end, got.run_end);
                    errors++;
                end
                if (got.stream_end !== want.stream_end)
                begin
                    $display("%0t: stream_end expected %b actual %b",
                             $time, want.stream_end, got.stream_end);
                    errors++;
                end
            end
        end
    end

    // sink side: choose next ready
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_if.ready <= 1'b0;
        end
        else if (!quiet_sink && $urandom_range(0, 99) < 15)
        begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
            out_if.ready <= 1'b0;
        end
        else
        begin
            out_if.ready <= 1'b1;
        end
    end

    initial
    begin
        errors = 0;
        stall_left = 0;
        quiet_sender = 1'b0;
        quiet_sink = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = RegWindowBits;
        cfg_data = 4'd0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        win_bits_reg = ResetWindowBits;
        len_bits_reg = ResetLengthBits;
        run_bits_reg = ResetRunBits;
        clear_stream_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_basic_streams();
        test_clamped_extremes();
        test_config_mid_stream();
        test_random_streams();
        set_config(ResetWindowBits, 4'(ResetLengthBits), 4'(ResetRunBits));
        test_basic_streams();

        wait_drained(SettleIdle);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
